// ===== design/mi3_pkg.sv =====
// Package for the 3x3 fixed-point matrix inverse.
// Holds word widths and the derived internal widths; no dependencies.
package mi3_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int NUM_ENT   = 9;

    // product, cofactor, determinant, dividend, divisor and remainder widths
    localparam int PROD_W = 2 * WORD_BITS;
    localparam int COF_W  = 2 * WORD_BITS + 1;
    localparam int DET_W  = 3 * WORD_BITS + 3;
    localparam int NUM_W0 = COF_W + 2 * FRAC_BITS + 1;
    localparam int NUM_W  = ((NUM_W0 > DET_W) ? NUM_W0 : DET_W) + 1;
    localparam int DEN_W  = DET_W + 1;
    localparam int REM_W  = (NUM_W > DEN_W) ? NUM_W : DEN_W;

    localparam int TDATA_W = ((NUM_ENT * WORD_BITS + 7) / 8) * 8;
    localparam int TUSER_W = 2;

    localparam int USER_SINGULAR  = 0;
    localparam int USER_SATURATED = 1;

endpackage

// ===== design/matrix3_inverse.sv =====
// Top level of the 3x3 fixed-point matrix inverse (adjugate over determinant).
// Depends on mi3_pkg.
//
//  channel | tdata                            | tuser                  | direction
//  s_*     | a_r0c0 a_r1c0 .. a_r2c2 (9 words) | -                      | in
//  m_*     | inv_r0c0 .. inv_r2c2 (9 words)    | singular, saturated    | out
//
// One matrix enters every cycle while the output is not stalled.
// The restoring divider resolves one quotient bit per stage in nine lanes.
// Reset clears every valid bit; payload registers hold no reset.
// A stalled output freezes the whole pipeline; s_tready follows that stall directly.
module matrix3_inverse
    import mi3_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,  // a_r0c0, a_r1c0, a_r2c0, a_r0c1, .. a_r2c2
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,  // inv_r0c0, inv_r1c0, inv_r2c0, inv_r0c1, .. inv_r2c2
    output logic [TUSER_W-1:0] m_tuser   // singular, saturated
);

    localparam int W = WORD_BITS;

    logic adv;

    logic signed [W-1:0]      a_in [NUM_ENT];

    logic                     st1_vld_reg;
    logic signed [PROD_W-1:0] st1_pa_reg [NUM_ENT];
    logic signed [PROD_W-1:0] st1_pb_reg [NUM_ENT];
    logic signed [W-1:0]      st1_m0_reg [3];

    logic                     st2_vld_reg;
    logic signed [COF_W-1:0]  st2_cof_reg [NUM_ENT];
    logic signed [W-1:0]      st2_m0_reg [3];

    logic                     st3_vld_reg;
    logic signed [2*W:0]      st3_pl_reg [3];
    logic signed [2*W:0]      st3_ph_reg [3];
    logic [COF_W-1:0]         st3_acof_reg [NUM_ENT];
    logic [NUM_ENT-1:0]       st3_cneg_reg;

    logic                     st4_vld_reg;
    logic signed [DET_W-1:0]  st4_t_reg [3];
    logic [COF_W-1:0]         st4_acof_reg [NUM_ENT];
    logic [NUM_ENT-1:0]       st4_cneg_reg;

    logic                     st5_vld_reg;
    logic signed [DET_W-1:0]  st5_det_reg;
    logic [COF_W-1:0]         st5_acof_reg [NUM_ENT];
    logic [NUM_ENT-1:0]       st5_cneg_reg;

    logic                     st6_vld_reg;
    logic [DET_W-1:0]         st6_adet_reg;
    logic                     st6_dneg_reg;
    logic                     st6_sing_reg;
    logic [COF_W-1:0]         st6_acof_reg [NUM_ENT];
    logic [NUM_ENT-1:0]       st6_cneg_reg;

    logic                     st7_vld_reg;
    logic [REM_W-1:0]         st7_num_reg [NUM_ENT];
    logic [REM_W-1:0]         st7_den_reg;
    logic [NUM_ENT-1:0]       st7_neg_reg;
    logic                     st7_sing_reg;

    logic                     dv_vld_reg  [W+1];
    logic [REM_W-1:0]         dv_r_reg    [W+1][NUM_ENT];
    logic [W-1:0]             dv_q_reg    [W+1][NUM_ENT];
    logic [REM_W-1:0]         dv_den_reg  [W+1];
    logic [NUM_ENT-1:0]       dv_neg_reg  [W+1];
    logic [NUM_ENT-1:0]       dv_over_reg [W+1];
    logic                     dv_sing_reg [W+1];

    logic                     out_vld_reg;
    logic [TDATA_W-1:0]       out_data_reg;
    logic [TUSER_W-1:0]       out_user_reg;
    logic [TDATA_W-1:0]       out_data_next;
    logic [TUSER_W-1:0]       out_user_next;

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // stage 1: the eighteen cofactor products
    for (genvar k = 0; k < NUM_ENT; k++)
    begin : g_in
        localparam int C  = k / 3;
        localparam int R  = k % 3;
        localparam int R1 = (R + 1) % 3;
        localparam int R2 = (R + 2) % 3;
        localparam int C1 = (C + 1) % 3;
        localparam int C2 = (C + 2) % 3;

        assign a_in[k] = $signed(s_tdata[k*W +: W]);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st1_pa_reg[k] <= PROD_W'(a_in[C1*3+R1]) * PROD_W'(a_in[C2*3+R2]);
                st1_pb_reg[k] <= PROD_W'(a_in[C2*3+R1]) * PROD_W'(a_in[C1*3+R2]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                st1_m0_reg[j] <= a_in[j*3];
                st2_m0_reg[j] <= st1_m0_reg[j];
            end
            // stage 2: cofactors
            for (int k = 0; k < NUM_ENT; k++)
            begin
                st2_cof_reg[k] <= COF_W'(st1_pa_reg[k]) - COF_W'(st1_pb_reg[k]);
            end
            // stage 3: split determinant products, cofactor magnitudes
            for (int j = 0; j < 3; j++)
            begin
                st3_pl_reg[j] <= (2*W+1)'(st2_m0_reg[j])
                                 * (2*W+1)'($signed({1'b0, st2_cof_reg[j*3][W-1:0]}));
                st3_ph_reg[j] <= (2*W+1)'(st2_m0_reg[j])
                                 * (2*W+1)'($signed(st2_cof_reg[j*3][COF_W-1:W]));
            end
            for (int k = 0; k < NUM_ENT; k++)
            begin
                st3_acof_reg[k] <= st2_cof_reg[k][COF_W-1] ? COF_W'(-st2_cof_reg[k])
                                                           : COF_W'(st2_cof_reg[k]);
                st3_cneg_reg[k] <= st2_cof_reg[k][COF_W-1];
            end
            // stage 4: recombine partial products
            for (int j = 0; j < 3; j++)
            begin
                st4_t_reg[j] <= (DET_W'(st3_ph_reg[j]) <<< W) + DET_W'(st3_pl_reg[j]);
            end
            st4_acof_reg <= st3_acof_reg;
            st4_cneg_reg <= st3_cneg_reg;
            // stage 5: determinant
            st5_det_reg  <= st4_t_reg[0] + st4_t_reg[1] + st4_t_reg[2];
            st5_acof_reg <= st4_acof_reg;
            st5_cneg_reg <= st4_cneg_reg;
            // stage 6: determinant magnitude
            st6_adet_reg <= st5_det_reg[DET_W-1] ? DET_W'(-st5_det_reg) : DET_W'(st5_det_reg);
            st6_dneg_reg <= st5_det_reg[DET_W-1];
            st6_sing_reg <= (st5_det_reg == '0);
            st6_acof_reg <= st5_acof_reg;
            st6_cneg_reg <= st5_cneg_reg;
            // stage 7: rounded dividend 2|n| + |d| over divisor 2|d|
            for (int k = 0; k < NUM_ENT; k++)
            begin
                st7_num_reg[k] <= (REM_W'(st6_acof_reg[(k%3)*3 + k/3]) << (2*FRAC_BITS + 1))
                                  + REM_W'(st6_adet_reg);
                st7_neg_reg[k] <= st6_cneg_reg[(k%3)*3 + k/3] ^ st6_dneg_reg;
            end
            st7_den_reg  <= REM_W'(st6_adet_reg) << 1;
            st7_sing_reg <= st6_sing_reg;
            // stage 8: quotient overflow check
            for (int k = 0; k < NUM_ENT; k++)
            begin
                dv_r_reg[0][k]       <= st7_num_reg[k];
                dv_q_reg[0][k]       <= '0;
                dv_over_reg[0][k]    <= ((st7_num_reg[k] >> W) >= st7_den_reg);
            end
            dv_den_reg[0]  <= st7_den_reg;
            dv_neg_reg[0]  <= st7_neg_reg;
            dv_sing_reg[0] <= st7_sing_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_vld_reg <= 1'b0;
            st2_vld_reg <= 1'b0;
            st3_vld_reg <= 1'b0;
            st4_vld_reg <= 1'b0;
            st5_vld_reg <= 1'b0;
            st6_vld_reg <= 1'b0;
            st7_vld_reg <= 1'b0;
            dv_vld_reg[0] <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            st1_vld_reg <= s_tvalid;
            st2_vld_reg <= st1_vld_reg;
            st3_vld_reg <= st2_vld_reg;
            st4_vld_reg <= st3_vld_reg;
            st5_vld_reg <= st4_vld_reg;
            st6_vld_reg <= st5_vld_reg;
            st7_vld_reg <= st6_vld_reg;
            dv_vld_reg[0] <= st7_vld_reg;
            out_vld_reg <= dv_vld_reg[W];
        end
    end

    // restoring division, one quotient bit per stage, MSB first
    for (genvar s = 0; s < W; s++)
    begin : g_div
        localparam int B = W - 1 - s;
        localparam logic [REM_W-1:0] LOW_MASK = (REM_W'(1) << B) - REM_W'(1);

        logic [REM_W:0]   diff [NUM_ENT];
        logic [REM_W-1:0] r_next [NUM_ENT];
        logic [W-1:0]     q_next [NUM_ENT];

        always_comb
        begin
            for (int k = 0; k < NUM_ENT; k++)
            begin
                diff[k] = {1'b0, dv_r_reg[s][k] >> B} - {1'b0, dv_den_reg[s]};
                r_next[k] = diff[k][REM_W] ? dv_r_reg[s][k]
                          : ((diff[k][REM_W-1:0] << B) | (dv_r_reg[s][k] & LOW_MASK));
                q_next[k] = dv_q_reg[s][k];
                q_next[k][B] = !diff[k][REM_W];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int k = 0; k < NUM_ENT; k++)
                begin
                    dv_r_reg[s+1][k] <= r_next[k];
                    dv_q_reg[s+1][k] <= q_next[k];
                end
                dv_den_reg[s+1]  <= dv_den_reg[s];
                dv_neg_reg[s+1]  <= dv_neg_reg[s];
                dv_over_reg[s+1] <= dv_over_reg[s];
                dv_sing_reg[s+1] <= dv_sing_reg[s];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[s+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_vld_reg[s+1] <= dv_vld_reg[s];
            end
        end
    end

    // clamp, apply sign, pack
    always_comb
    begin
        logic [W-1:0] lim;
        logic [W-1:0] mag;
        logic         clamp;
        logic         sat;
        out_data_next = '0;
        sat = 1'b0;
        for (int k = 0; k < NUM_ENT; k++)
        begin
            lim   = dv_neg_reg[W][k] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            clamp = dv_over_reg[W][k] || (dv_q_reg[W][k] > lim);
            mag   = clamp ? lim : dv_q_reg[W][k];
            sat   = sat | clamp;
            if (!dv_sing_reg[W])
            begin
                out_data_next[k*W +: W] = dv_neg_reg[W][k] ? W'(-mag) : mag;
            end
        end
        out_user_next = '0;
        out_user_next[USER_SINGULAR]  = dv_sing_reg[W];
        out_user_next[USER_SATURATED] = sat && !dv_sing_reg[W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

endmodule

// ===== design/matrix3_inverse_checker.sv =====
// Port-level checker for matrix3_inverse, bound to the top level.
// Depends on mi3_pkg and matrix3_inverse.
module matrix3_inverse_checker
    import mi3_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [TUSER_W-1:0] m_tuser
);

    a_no_valid_in_reset: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input held off without an output stall");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[USER_SINGULAR]) |-> (m_tdata == '0 && !m_tuser[USER_SATURATED]))
        else $error("singular transfer with nonzero data or saturation");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled output transfer changed");

endmodule

bind matrix3_inverse matrix3_inverse_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
